/* src/tsol_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Self-organising list package
// Shared constants, command codes, sequencer states and the result type.
// ----------------------------------------------------------------------------
package tsol_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             status;
        logic [POS_W-1:0] found_position;
        logic [CNT_W-1:0] entry_count;
    } result_t;

endpackage
`default_nettype wire

/* src/tsol_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* src/tsol_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Self-organising list sequencer
// Appends in the idle state, or walks the list through one RAM read port and
// one shared comparator, then does the transpose swap or the closing shift.
// ----------------------------------------------------------------------------
module tsol_engine
    import tsol_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [VALUE_W-1:0]    value,
    output logic                       res_valid,
    output result_t                    res,
    input  wire logic                  res_take,
    output logic                       ram_we,
    output logic      [AW-1:0]         ram_waddr,
    output logic      [VALUE_BITS-1:0] ram_wdata,
    output logic      [AW-1:0]         ram_raddr,
    input  wire logic [VALUE_BITS-1:0] ram_rdata
);

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] prev_reg, prev_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic                  status_reg, status_next;

    logic [63:0]           value_ext;
    logic [VALUE_BITS-1:0] v_in;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         idx_dec;
    logic                  match;
    logic                  more;
    logic [AW+3:0]         pos_ext;
    logic [CW+4:0]         count_ext;

    assign value_ext = {32'b0, value};
    assign v_in      = value_ext[VALUE_BITS-1:0];
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign match     = (ram_rdata == val_reg);
    assign more      = (idx_inc < count_reg);
    assign pos_ext   = {4'b0, pos_reg};
    assign count_ext = {5'b0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        prev_reg   <= prev_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        prev_next   = prev_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_dec[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_inc[AW-1:0];
        res_valid   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = '0;
                if (in_valid)
                begin
                    cmd_next    = command;
                    val_next    = v_in;
                    status_next = 1'b1;
                    pos_next    = '0;
                    idx_next    = '0;
                    state_next  = ST_DONE;
                    unique case (command) inside
                        CMD_INSERT:
                        begin
                            if (count_reg < CW'(DEPTH))
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[AW-1:0];
                                ram_wdata   = v_in;
                                count_next  = count_reg + 1'b1;
                                status_next = 1'b0;
                            end
                        end
                        CMD_SEARCH, CMD_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    status_next = 1'b0;
                    pos_next    = idx_reg[AW-1:0];
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        if (idx_reg != '0)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = val_reg;
                            state_next = ST_SWAP;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else if (more)
                    begin
                        idx_next   = idx_inc;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    prev_next = ram_rdata;
                    if (more)
                    begin
                        idx_next = idx_inc;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SWAP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = prev_reg;
                state_next = ST_DONE;
            end
            ST_SHIFT:
            begin
                ram_we = 1'b1;
                if (more)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall           = (state_reg != ST_IDLE);
    assign res.status         = status_reg;
    assign res.found_position = pos_ext[3:0];
    assign res.entry_count    = count_ext[4:0];

endmodule
`default_nettype wire

/* src/transpose_self_organizing_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Self-organising list with transpose
// Ordered value list supporting append, search with transpose and remove.
// ----------------------------------------------------------------------------
// Usage: an input transaction (in_valid, command, value) is taken when
// in_valid is high and in_stall is low. Each one yields exactly one result
// transaction (status, found_position, entry_count) on the output channel.
// The list lives in a RAM with one read and one write port; a sequencer
// reads one entry per cycle and a single comparator tests it.
// Insert and an unknown command go straight to the result. Search and remove
// scan the list up to the match, or to its end on a miss; a search match past
// the head then adds a swap, and a remove match a shift of each entry behind
// it. in_stall stays high while a transaction is in progress.
// Reset clears the entry count and the control state; the RAM is not
// cleared, as only entries below the count are ever used. While the
// receiver stalls, the result waits in the output register and the block
// can start the next transaction, holding its own result until the
// register is free.
// ----------------------------------------------------------------------------
module transpose_self_organizing_list
    import tsol_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    status,
    output logic      [POS_W-1:0]   found_position,
    output logic      [CNT_W-1:0]   entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic    eng_valid;
    result_t eng_res;
    logic    res_take;

    logic    out_valid_reg;
    result_t out_res_reg;

    tsol_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsol_engine #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .res_valid (eng_valid),
        .res       (eng_res),
        .res_take  (res_take),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign res_take = eng_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign found_position = out_res_reg.found_position;
    assign entry_count    = out_res_reg.entry_count;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a transaction without going busy");

    a_miss_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> found_position == '0)
        else $error("failed transaction reports a non-zero position");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        eng_valid && out_valid_reg && out_stall |=> eng_valid)
        else $error("finished result dropped while the output was stalled");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the transpose self-organising list
// Directed and random insert, search, remove and unused-command transactions
// with random idling on both channels. Fixed directed rows expect a given
// result; every other one is predicted from a shadow list updated on accept.
// ----------------------------------------------------------------------------
module tb
    import tsol_pkg::*;
();

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 10;
    localparam int RAND_N      = 1423;
    localparam int POOL_N      = 12;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam result_t PREDICTED = '0;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] val;
        bit                 fixed;
        result_t            res;
    } list_op_row_t;

    localparam int DIR_N = 27;

    list_op_row_t directed_rows [DIR_N] = '{
        '{CMD_SEARCH, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 5'd0}},
        '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 5'd0}},
        '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd0, 5'd0}},
        '{CMD_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 5'd1}},
        '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd2}},
        '{CMD_INSERT, 32'h5555_5555, 1'b1, '{1'b0, 4'd0, 5'd3}},
        '{CMD_INSERT, 32'hAAAA_AAAA, 1'b1, '{1'b0, 4'd0, 5'd4}},
        '{CMD_INSERT, 32'h0000_0001, 1'b1, '{1'b0, 4'd0, 5'd5}},
        '{CMD_INSERT, 32'h0000_0007, 1'b1, '{1'b0, 4'd0, 5'd6}},
        '{CMD_INSERT, 32'h0000_0001, 1'b1, '{1'b0, 4'd0, 5'd7}},
        '{CMD_INSERT, 32'h0000_0010, 1'b1, '{1'b0, 4'd0, 5'd8}},
        '{CMD_INSERT, 32'h0000_0020, 1'b1, '{1'b0, 4'd0, 5'd9}},
        '{CMD_INSERT, 32'h0000_0030, 1'b1, '{1'b0, 4'd0, 5'd10}},
        '{CMD_INSERT, 32'h0000_0040, 1'b1, '{1'b0, 4'd0, 5'd11}},
        '{CMD_INSERT, 32'h0000_0050, 1'b1, '{1'b0, 4'd0, 5'd12}},
        '{CMD_INSERT, 32'h0000_0060, 1'b1, '{1'b0, 4'd0, 5'd13}},
        '{CMD_INSERT, 32'h0000_0070, 1'b1, '{1'b0, 4'd0, 5'd14}},
        '{CMD_INSERT, 32'h0000_0080, 1'b1, '{1'b0, 4'd0, 5'd15}},
        '{CMD_INSERT, 32'h0000_0090, 1'b1, '{1'b0, 4'd0, 5'd16}},
        '{CMD_INSERT, 32'h1234_5678, 1'b1, '{1'b1, 4'd0, 5'd16}},
        '{CMD_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 5'd16}},
        '{CMD_SEARCH, 32'h0000_0090, 1'b0, PREDICTED},
        '{CMD_SEARCH, 32'h0000_0001, 1'b0, PREDICTED},
        '{CMD_UNUSED, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 5'd16}},
        '{CMD_REMOVE, 32'h0000_0080, 1'b0, PREDICTED},
        '{CMD_REMOVE, 32'h0000_0000, 1'b0, PREDICTED},
        '{CMD_REMOVE, 32'hDEAD_BEEF, 1'b0, PREDICTED}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_stall;
    logic               status;
    logic [POS_W-1:0]   found_position;
    logic [CNT_W-1:0]   entry_count;

    logic [VALUE_W-1:0] shadow_list [DEPTH_DEF];
    logic [CNT_W-1:0]   shadow_count;
    logic [VALUE_W-1:0] value_pool [POOL_N];
    result_t            pending_results [$];
    int unsigned        mismatches;
    int unsigned        cycle_count;
    bit                 idle_off;
    bit                 hold_off_req;

    transpose_self_organizing_list #(
        .DEPTH      (DEPTH_DEF),
        .VALUE_BITS (VALUE_BITS_DEF)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic result_t predict_list_op(input logic [CMD_W-1:0] cmd,
                                                input logic [VALUE_W-1:0] val);
        result_t            r;
        int                 hit;
        logic [VALUE_W-1:0] held;
        r.status         = 1'b1;
        r.found_position = '0;
        hit              = -1;
        for (int i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_list[i] == val)
                hit = i;
        case (cmd)
            CMD_INSERT:
                if (shadow_count < DEPTH_DEF)
                begin
                    shadow_list[shadow_count] = val;
                    shadow_count++;
                    r.status = 1'b0;
                end
            CMD_SEARCH:
                if (hit >= 0)
                begin
                    r.status         = 1'b0;
                    r.found_position = hit[POS_W-1:0];
                    if (hit > 0)
                    begin
                        held               = shadow_list[hit - 1];
                        shadow_list[hit - 1] = shadow_list[hit];
                        shadow_list[hit]     = held;
                    end
                end
            CMD_REMOVE:
                if (hit >= 0)
                begin
                    r.status         = 1'b0;
                    r.found_position = hit[POS_W-1:0];
                    for (int i = hit; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                end
            default:
                ;
        endcase
        r.entry_count = shadow_count;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4 && shadow_count > 0)
            return shadow_list[$urandom_range(0, shadow_count - 1)];
        if (r < 8)
            return value_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom();
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                             input bit fixed, input result_t fixed_res,
                             input int gap, input bit drain);
        result_t r;
        @(negedge clk);
        if (gap > 0 || drain)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            if (drain)
                do @(negedge clk); while (pending_results.size() != 0);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do @(posedge clk); while (in_stall);
        r = predict_list_op(cmd, val);
        pending_results.push_back(fixed ? fixed_res : r);
    endtask

    function automatic int pick_gap();
        if (!idle_off && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 5);
        return 0;
    endfunction

    // The output side idles in short bursts, and once holds off for a long
    // stretch so that the block fills up and stalls its input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!idle_off && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, found_position);
                    mismatches++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, entry_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** transpose_self_organizing_list: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int                 ins_pct;
        int unsigned        r;
        logic [CMD_W-1:0]   cmd;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_INSERT;
        value        = '0;
        shadow_count = '0;
        mismatches   = 0;
        idle_off     = 1'b0;
        hold_off_req = 1'b0;
        ins_pct      = 50;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++)
            value_pool[i] = $urandom();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].fixed,
                      directed_rows[i].res, pick_gap(), 1'b0);

        for (int k = 0; k < RAND_N; k++)
        begin
            idle_off = (k % 300 >= 250) || (k >= RAND_N - 150);
            if (k % 100 == 0)
                ins_pct = (k / 100) % 2 == 0 ? $urandom_range(55, 80) : $urandom_range(10, 35);
            if (k == 400)
                hold_off_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                cmd = CMD_INSERT;
            else if (r >= 97)
                cmd = CMD_UNUSED;
            else if (r[0])
                cmd = CMD_SEARCH;
            else
                cmd = CMD_REMOVE;
            send_item(cmd, pick_value(), 1'b0, PREDICTED, pick_gap(), k == 800);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** transpose_self_organizing_list: PASSED **");
        else
            $display("** transpose_self_organizing_list: FAILED **");
        $finish;
    end

endmodule
